// ===== sv/crc_rsc_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the record stream checker.
// Used by the channel interfaces and by every module of the block; depends on nothing.
package crc_rsc_pkg;

  // Stream format constants.
  localparam logic [31:0] FILE_SIGNATURE     = 32'h3144_3250;
  localparam logic [31:0] REC_SIGNATURE      = 32'h324D_5246;
  localparam logic [31:0] DEFAULT_MAX_RECORD = 32'd64 * 32'd1024 * 32'd1024;
  localparam logic [31:0] CRC_POLY           = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES           = 32'hFFFF_FFFF;
  localparam logic [15:0] FILE_HDR_BYTES     = 16'd32;
  localparam logic [31:0] REC_HDR_BYTES      = 32'd16;
  localparam logic [47:0] COUNT_MAX          = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] DEFAULT_VERSION    = 16'd1;

  // Index of the last byte of each header.
  localparam logic [31:0] FILE_HDR_LAST = 32'd31;
  localparam logic [31:0] REC_HDR_LAST  = 32'd15;

  // Configuration register indexes.
  localparam int          CFG_IDX_W         = 1;
  localparam logic [0:0]  CFG_EXPECTED_VER  = 1'b0;
  localparam logic [0:0]  CFG_MAX_RECORD    = 1'b1;
  localparam int          CFG_DATA_W        = 32;

  // Parsing phase.
  typedef enum logic [1:0] {
    PH_FILE,
    PH_RECHDR,
    PH_PAYLOAD,
    PH_DRAIN
  } phase_t;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_PAYLOAD     = 3'd0,
    EV_HEADER_OK   = 3'd1,
    EV_RECORD_OK   = 3'd2,
    EV_CLEAN_END   = 3'd3,
    EV_HEADER_BAD  = 3'd4,
    EV_RECORD_BAD  = 3'd5
  } event_t;

  // One input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } item_t;

  // One result item.
  typedef struct packed {
    event_t      event_res;
    logic [7:0]  payload_byte;
    logic [31:0] frame_width;
    logic [31:0] frame_height;
    logic [63:0] frame_rate_bits;
    logic [63:0] scale_bits;
    logic [31:0] record_bytes;
    logic [47:0] good_bytes;
  } result_t;

  // Reflected CRC-32 update by one byte; unrolls to an XOR network.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== sv/crc_rsc_ifs.sv =====
// Valid/ready channel interfaces for the input byte stream and the result stream.
// Imports crc_rsc_pkg; the payload widths are written out in the interfaces.
interface crc_rsc_in_if import crc_rsc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, data_byte, end_of_file, input ready);
  modport sink   (input valid, data_byte, end_of_file, output ready);
endinterface

interface crc_rsc_out_if import crc_rsc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  payload_byte;
  logic [31:0] frame_width;
  logic [31:0] frame_height;
  logic [63:0] frame_rate_bits;
  logic [63:0] scale_bits;
  logic [31:0] record_bytes;
  logic [47:0] good_bytes;

  modport source (output valid, event_res, payload_byte, frame_width, frame_height,
                  frame_rate_bits, scale_bits, record_bytes, good_bytes,
                  input ready);
  modport sink   (input valid, event_res, payload_byte, frame_width, frame_height,
                  frame_rate_bits, scale_bits, record_bytes, good_bytes,
                  output ready);
endinterface

// ===== sv/crc_rsc_in_stage.sv =====
// Input register of the record stream checker: holds one accepted item for the engine.
// Depends on crc_rsc_pkg and the input channel interface.
module crc_rsc_in_stage import crc_rsc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  crc_rsc_in_if.sink   in_item,
  input  logic         take,
  output logic         item_valid,
  output item_t        item
);

  logic  in_valid_r;
  logic  in_valid_nxt;
  item_t in_data_r;
  logic  load;

  // The register frees up whenever the engine takes its item.
  assign in_item.ready = !in_valid_r || take;
  assign load          = in_item.valid && in_item.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (load) begin
      in_valid_nxt = 1'b1;
    end else if (take) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_data_r.data_byte   <= in_item.data_byte;
      in_data_r.end_of_file <= in_item.end_of_file;
    end
  end

  assign item_valid = in_valid_r;
  assign item       = in_data_r;

endmodule

// ===== sv/crc_rsc_engine.sv =====
// Parsing engine: file header check, record header check, payload CRC and byte counting.
// Holds the configuration registers and all parse state; depends on crc_rsc_pkg.
module crc_rsc_engine import crc_rsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  fire,
  input  item_t                 item,
  output logic                  res_valid,
  output result_t               res
);

  phase_t       phase_r, phase_nxt;
  logic [31:0]  idx_r, idx_nxt;
  logic [255:0] fhdr_r, fhdr_nxt;
  logic [127:0] rhdr_r, rhdr_nxt;
  logic [31:0]  crc_r, crc_nxt;
  logic [47:0]  good_r, good_nxt;
  logic [15:0]  ver_r;
  logic [31:0]  maxrec_r;

  logic [7:0]   b;
  logic [255:0] fhdr_shift;
  logic [127:0] rhdr_shift;
  logic [31:0]  idx_inc;
  logic [31:0]  crc_step;
  logic         file_ok;
  logic         rec_hdr_ok;
  logic [127:0] fin_hdr;
  logic [31:0]  fin_size;
  logic [31:0]  fin_crc;
  logic         fin_ok;
  logic [48:0]  fin_sum;
  logic [47:0]  fin_good;

  assign b          = item.data_byte;
  assign fhdr_shift = {b, fhdr_r[255:8]};
  assign rhdr_shift = {b, rhdr_r[127:8]};
  assign idx_inc    = idx_r + 32'd1;
  assign crc_step   = crc_byte(crc_r, b);

  // File header fields, judged on the shifted value at its last byte.
  assign file_ok = (fhdr_shift[31:0] == FILE_SIGNATURE) &&
                   (fhdr_shift[47:32] == ver_r) &&
                   (fhdr_shift[63:48] == FILE_HDR_BYTES) &&
                   (fhdr_shift[95:64] != 32'd0) &&
                   (fhdr_shift[127:96] != 32'd0);

  assign rec_hdr_ok = (rhdr_shift[31:0] == REC_SIGNATURE) &&
                      (rhdr_shift[127:96] == 32'd0) &&
                      (rhdr_shift[63:32] >= REC_HDR_BYTES) &&
                      (rhdr_shift[63:32] <= maxrec_r);

  // Record completion: an empty record finishes on its header, otherwise on the last byte.
  assign fin_hdr  = (phase_r == PH_RECHDR) ? rhdr_shift : rhdr_r;
  assign fin_crc  = (phase_r == PH_RECHDR) ? ALL_ONES : crc_step;
  assign fin_size = fin_hdr[63:32];
  assign fin_ok   = (~fin_crc == fin_hdr[95:64]);
  assign fin_sum  = {1'b0, good_r} + {17'd0, fin_size};
  assign fin_good = fin_sum[48] ? COUNT_MAX : fin_sum[47:0];

  // Next state and result for the item being taken.
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    fhdr_nxt  = fhdr_r;
    rhdr_nxt  = rhdr_r;
    crc_nxt   = crc_r;
    good_nxt  = good_r;
    res_valid = 1'b0;
    res       = '0;
    unique case (phase_r)
      PH_FILE: begin
        if (item.end_of_file) begin
          idx_nxt       = 32'd0;
          res_valid     = 1'b1;
          res.event_res = EV_HEADER_BAD;
        end else begin
          fhdr_nxt = fhdr_shift;
          idx_nxt  = idx_inc;
          if (idx_r == FILE_HDR_LAST) begin
            res_valid = 1'b1;
            idx_nxt   = 32'd0;
            if (file_ok) begin
              phase_nxt           = PH_RECHDR;
              good_nxt            = {32'd0, FILE_HDR_BYTES};
              crc_nxt             = ALL_ONES;
              res.event_res       = EV_HEADER_OK;
              res.frame_width     = fhdr_shift[95:64];
              res.frame_height    = fhdr_shift[127:96];
              res.frame_rate_bits = fhdr_shift[191:128];
              res.scale_bits      = fhdr_shift[255:192];
              res.good_bytes      = {32'd0, FILE_HDR_BYTES};
            end else begin
              phase_nxt     = PH_DRAIN;
              res.event_res = EV_HEADER_BAD;
            end
          end
        end
      end
      PH_RECHDR: begin
        if (item.end_of_file) begin
          phase_nxt      = PH_FILE;
          idx_nxt        = 32'd0;
          crc_nxt        = ALL_ONES;
          good_nxt       = '0;
          res_valid      = 1'b1;
          res.event_res  = (idx_r == 32'd0) ? EV_CLEAN_END : EV_RECORD_BAD;
          res.good_bytes = good_r;
        end else begin
          rhdr_nxt = rhdr_shift;
          idx_nxt  = idx_inc;
          if (idx_r == REC_HDR_LAST) begin
            idx_nxt = 32'd0;
            if (!rec_hdr_ok) begin
              phase_nxt      = PH_DRAIN;
              res_valid      = 1'b1;
              res.event_res  = EV_RECORD_BAD;
              res.good_bytes = good_r;
            end else if (rhdr_shift[63:32] == REC_HDR_BYTES) begin
              res_valid = 1'b1;
              if (fin_ok) begin
                good_nxt         = fin_good;
                crc_nxt          = ALL_ONES;
                res.event_res    = EV_RECORD_OK;
                res.record_bytes = fin_size;
                res.good_bytes   = fin_good;
              end else begin
                phase_nxt      = PH_DRAIN;
                res.event_res  = EV_RECORD_BAD;
                res.good_bytes = good_r;
              end
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        if (item.end_of_file) begin
          phase_nxt      = PH_FILE;
          idx_nxt        = 32'd0;
          crc_nxt        = ALL_ONES;
          good_nxt       = '0;
          res_valid      = 1'b1;
          res.event_res  = EV_RECORD_BAD;
          res.good_bytes = good_r;
        end else begin
          res_valid        = 1'b1;
          res.payload_byte = b;
          if (idx_inc < (rhdr_r[63:32] - REC_HDR_BYTES)) begin
            crc_nxt        = crc_step;
            idx_nxt        = idx_inc;
            res.event_res  = EV_PAYLOAD;
            res.good_bytes = good_r;
          end else if (fin_ok) begin
            phase_nxt        = PH_RECHDR;
            idx_nxt          = 32'd0;
            crc_nxt          = ALL_ONES;
            good_nxt         = fin_good;
            res.event_res    = EV_RECORD_OK;
            res.record_bytes = fin_size;
            res.good_bytes   = fin_good;
          end else begin
            phase_nxt      = PH_DRAIN;
            crc_nxt        = crc_step;
            idx_nxt        = idx_inc;
            res.event_res  = EV_RECORD_BAD;
            res.good_bytes = good_r;
          end
        end
      end
      PH_DRAIN: begin
        // Bytes are dropped; the end item starts a new file.
        if (item.end_of_file) begin
          phase_nxt = PH_FILE;
          idx_nxt   = 32'd0;
          crc_nxt   = ALL_ONES;
          good_nxt  = '0;
        end
      end
      default: begin
        phase_nxt = PH_FILE;
      end
    endcase
  end

  // Parse state advances only when an item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FILE;
      idx_r   <= 32'd0;
      crc_r   <= ALL_ONES;
      good_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      crc_r   <= crc_nxt;
      good_r  <= good_nxt;
    end
  end

  // Header shift registers are fully refilled before each use.
  always_ff @(posedge clk) begin
    if (fire) begin
      fhdr_r <= fhdr_nxt;
      rhdr_r <= rhdr_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r    <= DEFAULT_VERSION;
      maxrec_r <= DEFAULT_MAX_RECORD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPECTED_VER: ver_r    <= cfg_wdata[15:0];
        CFG_MAX_RECORD:   maxrec_r <= cfg_wdata[31:0];
        default:          ;
      endcase
    end
  end

endmodule

// ===== sv/crc_rsc_out_stage.sv =====
// Output register of the record stream checker: holds one result item until taken.
// Depends on crc_rsc_pkg and the result channel interface.
module crc_rsc_out_stage import crc_rsc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_load,
  input  result_t       res,
  output logic          can_take,
  crc_rsc_out_if.source out_item
);

  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_res_r;

  // A new result may enter when the register is empty or drains this cycle.
  assign can_take = !out_valid_r || out_item.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  // Drive the channel from the held result.
  assign out_item.valid           = out_valid_r;
  assign out_item.event_res       = out_res_r.event_res;
  assign out_item.payload_byte    = out_res_r.payload_byte;
  assign out_item.frame_width     = out_res_r.frame_width;
  assign out_item.frame_height    = out_res_r.frame_height;
  assign out_item.frame_rate_bits = out_res_r.frame_rate_bits;
  assign out_item.scale_bits      = out_res_r.scale_bits;
  assign out_item.record_bytes    = out_res_r.record_bytes;
  assign out_item.good_bytes      = out_res_r.good_bytes;

endmodule

// ===== sv/crc_record_stream_checker_core.sv =====
// Top level of the record stream checker: input register, parsing engine, output register.
// Depends on crc_rsc_pkg, the channel interfaces and the three stage modules.
//
//   Channel   Direction  Handshake          Payload
//   in_item   sink       valid/ready        data_byte, end_of_file
//   out_item  source     valid/ready        event_res, payload_byte, header fields,
//                                           record_bytes, good_bytes
//   cfg_*     write      cfg_we             cfg_index (0 version, 1 max record), cfg_wdata
//
// One item per cycle sustained while the result channel is ready; an item is held in the input
// register and its result in the output register.
// The rate is set by the single-byte CRC XOR network and the header compares in the engine.
// Synchronous active-low reset empties both registers and starts a new file.
// A stalled result register holds the engine, and the input register then fills and stalls.
// Items that cause no result pass through the engine without touching the output register.
module crc_record_stream_checker_core import crc_rsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  crc_rsc_in_if.sink            in_item,
  crc_rsc_out_if.source         out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic    item_valid;
  item_t   item;
  logic    can_take;
  logic    fire;
  logic    res_valid;
  result_t res;

  // The engine takes an item when it has one and the result register has room.
  assign fire = item_valid && can_take;

  crc_rsc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  crc_rsc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  crc_rsc_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_load (fire && res_valid),
    .res      (res),
    .can_take (can_take),
    .out_item (out_item)
  );

endmodule
